>>> rtl/rdq_pkg.sv
// rdq_pkg: shared types and constants for the reversible deque.
// Holds ring depth, command and status codes, and the request/result structs.
// No dependencies.
package rdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam logic [2:0] CMD_POP_BACK   = 3'd0;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd1;
    localparam logic [2:0] CMD_REVERSE    = 3'd2;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd3;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd4;

    localparam logic [1:0] ST_POPPED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
    } t_out_item;

endpackage

>>> rtl/reversible_deque.sv
// reversible_deque: top level of the double-ended queue with reverse flag.
// Depends on rdq_pkg (types, codes, depth) and rdq_ram (entry storage).
//
// A double-ended queue of DEPTH 32-bit words kept in a ring buffer inside one
// synchronous RAM. The head pointer, the entry count and the reverse flag sit
// in flops; the reverse command only toggles the flag, which swaps the
// logical front and back ends. One request is taken per clock while no result
// is held back by the receiver. Pushes write the RAM in the cycle they are
// accepted and give no result unless the ring is full (status full, word
// dropped). A pop looks up the RAM at acceptance and its result is presented
// the next cycle; the popped word comes straight from the RAM's registered
// read port. Pops on an empty queue answer with status empty. A result is
// held in the output register until taken, and a new request is accepted in
// the same cycle the held result leaves, so the sustained rate is one request
// per cycle while the receiver takes each result at once. Unused command
// codes are accepted and ignored. No clearing pass is needed after reset.
module reversible_deque
    import rdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // control state
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_rev, n_rev;

    // result register; popped word itself stays in the RAM read register
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status, n_out_status;
    logic              r_out_from_ram, n_out_from_ram;

    logic              accept;
    logic              front_cmd;
    logic              phys_front;
    logic              is_empty;
    logic              is_full;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  back_sum;
    logic [ADDR_W-1:0] back_idx;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [31:0]       ram_rd_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign front_cmd  = (i_in_data.command == CMD_POP_FRONT) ||
                        (i_in_data.command == CMD_PUSH_FRONT);
    // reverse flag swaps which physical end a logical command touches
    assign phys_front = front_cmd ^ r_rev;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_W'(DEPTH));

    // one past the physical back; pops step back one
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    always_comb begin
        back_sum = tail_sum;
        if (i_in_data.command == CMD_POP_BACK || i_in_data.command == CMD_POP_FRONT) begin
            back_sum = tail_sum - SUM_W'(1);
        end
        if (back_sum >= SUM_W'(DEPTH)) begin
            back_sum = back_sum - SUM_W'(DEPTH);
        end
        back_idx = back_sum[ADDR_W-1:0];
    end

    assign head_dec = (r_head == '0) ? ADDR_W'(DEPTH - 1) : r_head - ADDR_W'(1);
    assign head_inc = (r_head == ADDR_W'(DEPTH - 1)) ? '0 : r_head + ADDR_W'(1);

    always_comb begin
        n_head         = r_head;
        n_count        = r_count;
        n_rev          = r_rev;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_status   = r_out_status;
        n_out_from_ram = r_out_from_ram;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = back_idx;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = back_idx;

        if (accept) begin
            unique case (i_in_data.command)
                CMD_POP_BACK, CMD_POP_FRONT: begin
                    n_out_valid = 1'b1;
                    if (is_empty) begin
                        n_out_status   = ST_EMPTY;
                        n_out_from_ram = 1'b0;
                    end else begin
                        n_out_status   = ST_POPPED;
                        n_out_from_ram = 1'b1;
                        ram_rd_en      = 1'b1;
                        n_count        = r_count - CNT_W'(1);
                        if (phys_front) begin
                            ram_rd_addr = r_head;
                            n_head      = head_inc;
                        end
                    end
                end
                CMD_REVERSE: begin
                    n_rev = !r_rev;
                end
                CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        n_out_valid    = 1'b1;
                        n_out_status   = ST_FULL;
                        n_out_from_ram = 1'b0;
                    end else begin
                        ram_wr_en = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                        if (phys_front) begin
                            ram_wr_addr = head_dec;
                            n_head      = head_dec;
                        end
                    end
                end
                default: begin
                    // unused codes: no effect
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status   <= n_out_status;
        r_out_from_ram <= n_out_from_ram;
    end

    rdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_out_valid             = r_out_valid;
    assign o_out_data.status       = r_out_status;
    assign o_out_data.popped_value = r_out_from_ram ? ram_rd_data : '0;

endmodule

>>> rtl/rdq_ram.sv
// rdq_ram: generic simple dual-port RAM, one write port, one registered read port.
// Standalone; no package dependency.
module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sim/reversible_deque_tb.sv
// reversible_deque_tb: self-checking testbench for the reversible deque.
// Depends on rdq_pkg and reversible_deque; a local deque model predicts every result
// and random idling on both handshakes stresses the flow control.
module reversible_deque_tb;
    import rdq_pkg::*;

    // command codes the block accepts and ignores
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REQUESTS = 4096;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    // stimulus list and expected results, each with write and read indexes
    t_in_item  req_list [MAX_REQUESTS];
    int        req_wr = 0;
    int        req_rd = 0;
    t_out_item exp_list [MAX_REQUESTS];
    int        exp_wr = 0;
    int        exp_rd = 0;
    int        requests_sent = 0;
    int        total_requests = 0;
    int        errors = 0;
    int        stall_cycles = 0;

    // deque model state
    logic [31:0] deque_store [DEPTH];
    int          deque_head = 0;
    int          deque_count = 0;
    logic        deque_reversed = 1'b0;

    // generator's running entry count, to steer toward full and empty
    int          gen_count = 0;

    always #2 clk = ~clk;

    reversible_deque uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    function automatic bit is_push(logic [2:0] cmd);
        return cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT;
    endfunction

    function automatic bit is_pop(logic [2:0] cmd);
        return cmd == CMD_POP_BACK || cmd == CMD_POP_FRONT;
    endfunction

    // Apply one accepted request to the model, recording any result it causes.
    function automatic void apply_command(t_in_item req);
        t_out_item res;
        bit        at_front;
        int        idx;
        res = '0;
        if (is_pop(req.command)) begin
            if (deque_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                // reverse flag swaps which physical end is the logical front
                at_front = (req.command == CMD_POP_FRONT) ^ deque_reversed;
                if (at_front) begin
                    res.popped_value = deque_store[deque_head];
                    deque_head = (deque_head + 1) % DEPTH;
                end else begin
                    idx = (deque_head + deque_count - 1) % DEPTH;
                    res.popped_value = deque_store[idx];
                end
                deque_count--;
                res.status = ST_POPPED;
            end
            exp_list[exp_wr] = res;
            exp_wr++;
        end else if (req.command == CMD_REVERSE) begin
            deque_reversed = ~deque_reversed;
        end else if (is_push(req.command)) begin
            if (deque_count >= DEPTH) begin
                res.status = ST_FULL;   // word dropped
                exp_list[exp_wr] = res;
                exp_wr++;
            end else begin
                at_front = (req.command == CMD_PUSH_FRONT) ^ deque_reversed;
                if (at_front) begin
                    deque_head = (deque_head + DEPTH - 1) % DEPTH;
                    deque_store[deque_head] = req.value;
                end else begin
                    idx = (deque_head + deque_count) % DEPTH;
                    deque_store[idx] = req.value;
                end
                deque_count++;
            end
        end
    endfunction

    task automatic add_request(input logic [2:0] cmd, input logic [31:0] val);
        t_in_item req;
        req.command = cmd;
        req.value   = val;
        if (req_wr < MAX_REQUESTS) begin
            req_list[req_wr] = req;
            req_wr++;
        end
        if (is_push(cmd) && gen_count < DEPTH)
            gen_count++;
        else if (is_pop(cmd) && gen_count > 0)
            gen_count--;
    endtask

    // mostly uniform words, with zero, all-ones and the signed extremes mixed in
    function automatic logic [31:0] random_word();
        if ($urandom_range(7) != 0)
            return $urandom();
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // weights in percent; the remainder goes to the unused codes
    function automatic logic [2:0] pick_command(int w_pop, int w_push, int w_rev);
        int r;
        r = $urandom_range(99);
        if (r < w_pop)
            return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        if (r < w_pop + w_push)
            return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (r < w_pop + w_push + w_rev)
            return CMD_REVERSE;
        return 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    endfunction

    // idle pattern: sender 35% / receiver 79%, then swapped, then no idling
    function automatic int idle_phase();
        if (requests_sent < total_requests / 3)
            return 0;
        if (requests_sent < 2 * total_requests / 3)
            return 1;
        return 2;
    endfunction

    function automatic bit sender_idles();
        case (idle_phase())
            0:       return $urandom_range(99) < 35;
            1:       return $urandom_range(99) < 79;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_idles();
        case (idle_phase())
            0:       return $urandom_range(99) < 79;
            1:       return $urandom_range(99) < 35;
            default: return 1'b0;
        endcase
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                apply_command(in_data);
                requests_sent <= requests_sent + 1;
            end
            if (!in_valid || in_ready) begin
                if (req_rd < req_wr && !sender_idles()) begin
                    in_valid <= 1'b1;
                    in_data  <= req_list[req_rd];
                    req_rd++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (exp_rd == exp_wr) begin
                    $error("result with no request awaiting it: status %0d, popped_value %0h",
                           out_data.status, out_data.popped_value);
                    errors++;
                end else begin
                    want = exp_list[exp_rd];
                    exp_rd++;
                    if (out_data.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, out_data.status);
                        errors++;
                    end
                    if (out_data.popped_value !== want.popped_value) begin
                        $error("popped_value mismatch: expected %0h, actual %0h",
                               want.popped_value, out_data.popped_value);
                        errors++;
                    end
                end
            end
            out_ready <= !receiver_idles();
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int full_hits;
        int n;
        logic [2:0] cmd;

        // directed: empty pops, signed extremes at both ends, reverse, unused codes
        add_request(CMD_POP_FRONT, random_word());
        add_request(CMD_POP_BACK, random_word());
        add_request(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        add_request(CMD_PUSH_FRONT, 32'h8000_0000);
        add_request(CMD_PUSH_BACK, 32'h0000_0000);
        add_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        add_request(CMD_POP_FRONT, 32'h0);
        add_request(CMD_POP_BACK, 32'h0);
        add_request(CMD_REVERSE, 32'h0);
        add_request(CMD_PUSH_FRONT, 32'h5555_5555);
        add_request(CMD_PUSH_BACK, 32'hAAAA_AAAA);
        add_request(CMD_POP_FRONT, 32'h0);
        add_request(CMD_POP_BACK, 32'h0);
        add_request(CMD_POP_FRONT, 32'h0);
        add_request(CMD_POP_BACK, 32'h0);
        add_request(CMD_POP_BACK, 32'h0);
        for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
            add_request(3'(c), random_word());
        add_request(CMD_REVERSE, 32'hFFFF_FFFF);
        add_request(CMD_POP_FRONT, 32'hFFFF_FFFF);

        // shallow mix: frequent empty pops and reverses
        for (n = 0; n < 30; n++)
            add_request(pick_command(40, 45, 10), random_word());

        // fill the ring, keep pushing at full a few times
        full_hits = 0;
        while (full_hits < 12 && req_wr < MAX_REQUESTS - 64) begin
            cmd = pick_command(2, 97, 1);
            if (is_push(cmd) && gen_count == DEPTH)
                full_hits++;
            add_request(cmd, random_word());
        end

        // drain toward empty
        for (n = 0; n < 40; n++)
            add_request(pick_command(85, 8, 5), random_word());

        total_requests = req_wr;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (req_rd != req_wr || in_valid)
            @(posedge clk);
        while (exp_rd != exp_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rdq_pkg.sv
rtl/rdq_ram.sv
rtl/reversible_deque.sv
sim/reversible_deque_tb.sv
